// ===== design/lru_order_tracker_core_macros.svh =====
// Assertion macros shared by the LRU order tracker RTL.
// Include this header with a bare file name; no other dependencies.
`ifndef LRU_ORDER_TRACKER_CORE_MACROS_SVH
`define LRU_ORDER_TRACKER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LOT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");
`define LOT_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("forbidden condition seen");
`else
`define LOT_ASSERT(label, clk, rst_n, prop)
`define LOT_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== design/lot_pkg.sv =====
// Types and constants of the LRU order tracker.
// No dependencies; imported by lru_order_tracker_core.
package lot_pkg;
	localparam int ACTION_W = 2;
	localparam int KEY_W    = 64;
	localparam int OCC_W    = 5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TOUCH  = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_QUERY  = 2'd2
	} action_t;

	typedef logic [KEY_W-1:0] key_t;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_OVERFLOW = 1'b1;
endpackage

// ===== design/lru_order_tracker_core.sv =====
// LRU order tracker: register store of keys ordered from least to most recently used.
// Depends on lot_pkg and lru_order_tracker_core_macros.svh.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   input   | in_valid / in_ready  | action, key
//   output  | out_valid / out_ready| found, oldest_key, status, occupancy
//
// One item per cycle unless the output stalls; the input register feeds the output register.
// The rate is set by the compare and one-position compaction of the key store.
// Reset clears the pipeline valid bits and the key count; the key store itself is not cleared.
// A stalled output holds its result, and the input register keeps taking items while the
// output register is free or being emptied in the same cycle.
`include "lru_order_tracker_core_macros.svh"
module lru_order_tracker_core #(
	parameter int CAPACITY = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [lot_pkg::ACTION_W-1:0] action,
	input  logic [lot_pkg::KEY_W-1:0]  key,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       found,
	output logic [lot_pkg::KEY_W-1:0]  oldest_key,
	output logic                       status,
	output logic [lot_pkg::OCC_W-1:0]  occupancy
);
	import lot_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int OW = (CW > OCC_W) ? CW : OCC_W;

	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	key_t                key_s1;
	logic                advance;

	key_t                keys_q [CAPACITY];
	key_t                keys_d [CAPACITY];
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_d;

	logic [CAPACITY-1:0] match;
	logic [CAPACITY-1:0] prefix;
	logic                hit;
	logic                found_d;
	logic                status_d;
	key_t                oldest_d;
	logic [OW-1:0]       occ_ext;

	logic                out_valid_q;
	logic                found_q;
	key_t                oldest_q;
	logic                status_q;
	logic [OCC_W-1:0]    occ_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			key_s1    <= key;
		end
	end

	always_comb begin
		prefix = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = (CW'(i) < count_q) && (keys_q[i] == key_s1);
		end
		prefix[0] = match[0];
		for (int i = 1; i < CAPACITY; i++) begin
			prefix[i] = prefix[i-1] | match[i];
		end
		hit = |match;
	end

	always_comb begin
		keys_d   = keys_q;
		count_d  = count_q;
		found_d  = 1'b0;
		status_d = STATUS_OK;
		case (action_t'(action_s1))
			ACT_TOUCH: begin
				if (hit) begin
					found_d = 1'b1;
					for (int i = 0; i < CAPACITY - 1; i++) begin
						if (prefix[i] && ((CW'(i) + CW'(1)) < count_q)) begin
							keys_d[i] = keys_q[i+1];
						end
					end
					for (int i = 0; i < CAPACITY; i++) begin
						if ((CW'(i) + CW'(1)) == count_q) begin
							keys_d[i] = key_s1;
						end
					end
				end else if (count_q == CW'(CAPACITY)) begin
					status_d = STATUS_OVERFLOW;
				end else begin
					for (int i = 0; i < CAPACITY; i++) begin
						if (CW'(i) == count_q) begin
							keys_d[i] = key_s1;
						end
					end
					count_d = count_q + CW'(1);
				end
			end
			ACT_REMOVE: begin
				if (hit) begin
					found_d = 1'b1;
					for (int i = 0; i < CAPACITY - 1; i++) begin
						if (prefix[i] && ((CW'(i) + CW'(1)) < count_q)) begin
							keys_d[i] = keys_q[i+1];
						end
					end
					count_d = count_q - CW'(1);
				end
			end
			ACT_QUERY: begin
				found_d = (count_q != '0);
			end
			default: begin
				found_d = 1'b0;
			end
		endcase
		oldest_d = (count_d != '0) ? keys_d[0] : '0;
		occ_ext  = OW'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			keys_q <= keys_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			found_q  <= found_d;
			oldest_q <= oldest_d;
			status_q <= status_d;
			occ_q    <= occ_ext[OCC_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign oldest_key = oldest_q;
	assign status     = status_q;
	assign occupancy  = occ_q;

	`LOT_ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CW'(CAPACITY))
	`LOT_ASSERT(a_keys_distinct, clk, arst_n, valid_s1 |-> $onehot0(match))
	`LOT_ASSERT(a_overflow_keeps_count, clk, arst_n,
		(advance && status_d == STATUS_OVERFLOW) |=> $stable(count_q))
	`LOT_ASSERT(a_remove_shrinks, clk, arst_n,
		(advance && action_s1 == ACT_REMOVE && hit) |=> (count_q == $past(count_q) - CW'(1)))
	`LOT_ASSERT(a_overflow_only_full, clk, arst_n,
		(status_d == STATUS_OVERFLOW) |-> (count_q == CW'(CAPACITY) && !hit))
endmodule
